FILE: design/spsq_pkg.sv
// ----------------------------------------------------------------------------
// spsq_pkg: shared types and codes of the stable priority sorted queue
// Entry layout, status and function codes, and the control word that the
// queue hands to each storage cell.
// ----------------------------------------------------------------------------
package spsq_pkg;

  // default number of storage cells
  localparam int unsigned QueueDepth = 16;

  // function codes of an input word
  localparam logic FuncInsert = 1'b0;
  localparam logic FuncRemove = 1'b1;

  // status codes of a result word
  localparam logic [1:0] StatusOk    = 2'd0;
  localparam logic [1:0] StatusFull  = 2'd1;
  localparam logic [1:0] StatusEmpty = 2'd2;

  // one stored process entry
  typedef struct packed {
    logic [7:0]  process_id;
    logic [15:0] burst_length;
    logic [3:0]  rank;
  } entry_t;

  // per-cell control from the queue
  typedef struct packed {
    logic       shift_in;   // insert that changes the store
    logic       shift_out;  // remove that changes the store
    logic       occupied;   // cell holds a valid entry
    logic [3:0] rank;       // rank of the incoming entry
  } cell_ctrl_t;

endpackage

FILE: design/spsq_cell.sv
// ----------------------------------------------------------------------------
// spsq_cell: one storage cell of the sorted queue
// Holds one entry. On an insert it keeps its entry, takes the new one, or
// takes its left neighbor's; on a remove it takes its right neighbor's.
// ----------------------------------------------------------------------------
module spsq_cell (
  input  logic                clk_i,
  input  spsq_pkg::cell_ctrl_t ctrl_i,
  input  spsq_pkg::entry_t    new_entry_i,
  input  spsq_pkg::entry_t    left_entry_i,
  input  spsq_pkg::entry_t    right_entry_i,
  input  logic                left_keep_i,
  output logic                keep_o,
  output spsq_pkg::entry_t    entry_o
);

  spsq_pkg::entry_t entry_q, entry_d;

  // entry stays put when it ranks at or before the new one
  assign keep_o = ctrl_i.occupied && (entry_q.rank <= ctrl_i.rank);

  // next entry selection
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.shift_in) begin
      if (!keep_o) begin
        if (left_keep_i) begin
          entry_d = new_entry_i;
        end else begin
          entry_d = left_entry_i;
        end
      end
    end else if (ctrl_i.shift_out) begin
      entry_d = right_entry_i;
    end
  end

  // payload register, no reset
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

FILE: design/stable_priority_sorted_queue.sv
// ----------------------------------------------------------------------------
// stable_priority_sorted_queue: bounded priority queue with stable insert
// A row of storage cells kept in rank order, with a registered result word.
// ----------------------------------------------------------------------------
// Each word is handled at once: all cells compare their rank with the
// incoming one in parallel and shift left or right in the same edge, so a
// new word is accepted in every cycle while the result register is free or
// being drained. The result appears in the cycle after acceptance and holds
// until taken. An insert (func 0) lands behind every stored entry of equal
// or smaller rank; a full queue drops it with status 1. A remove (func 1)
// returns the head, the smallest rank; on an empty queue it gives status 2
// and zero fields. fill_level is the entry count after the word, modulo 32.
// No clearing pass after reset: only the count and the valid flag are reset.
// ----------------------------------------------------------------------------
module stable_priority_sorted_queue #(
  parameter int unsigned QueueDepth = spsq_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        func_i,
  input  logic [7:0]  process_id_i,
  input  logic [15:0] burst_length_i,
  input  logic [3:0]  rank_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [7:0]  out_process_id_o,
  output logic [15:0] out_burst_length_o,
  output logic [3:0]  out_rank_o,
  output logic [4:0]  fill_level_o
);

  localparam int unsigned CountW = $clog2(QueueDepth + 1);

  logic [CountW-1:0] count_q, count_d;
  logic              out_valid_q;
  logic [1:0]        status_q, status_d;
  spsq_pkg::entry_t  result_q, result_d;

  logic accept, is_full, is_empty, do_insert, do_remove;

  spsq_pkg::entry_t new_entry;
  spsq_pkg::entry_t cell_entry [QueueDepth];
  logic [QueueDepth-1:0] cell_keep;

  // handshake: the result register parts the two sides
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign is_full   = (count_q == CountW'(QueueDepth));
  assign is_empty  = (count_q == '0);
  assign do_insert = accept && (func_i == spsq_pkg::FuncInsert) && !is_full;
  assign do_remove = accept && (func_i == spsq_pkg::FuncRemove) && !is_empty;

  assign new_entry.process_id   = process_id_i;
  assign new_entry.burst_length = burst_length_i;
  assign new_entry.rank         = rank_i;

  // row of cells
  for (genvar g = 0; g < QueueDepth; g++) begin : g_cell
    spsq_pkg::cell_ctrl_t ctrl;
    spsq_pkg::entry_t     left_entry, right_entry;
    logic                 left_keep;

    assign ctrl.shift_in  = do_insert;
    assign ctrl.shift_out = do_remove;
    assign ctrl.occupied  = (CountW'(g) < count_q);
    assign ctrl.rank      = rank_i;

    if (g == 0) begin : g_first
      assign left_entry = new_entry;
      assign left_keep  = 1'b1;
    end else begin : g_mid
      assign left_entry = cell_entry[g-1];
      assign left_keep  = cell_keep[g-1];
    end

    if (g == QueueDepth - 1) begin : g_last
      assign right_entry = cell_entry[g];
    end else begin : g_inner
      assign right_entry = cell_entry[g+1];
    end

    spsq_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .new_entry_i   (new_entry),
      .left_entry_i  (left_entry),
      .right_entry_i (right_entry),
      .left_keep_i   (left_keep),
      .keep_o        (cell_keep[g]),
      .entry_o       (cell_entry[g])
    );
  end

  // count and result word
  always_comb begin
    count_d  = count_q;
    status_d = spsq_pkg::StatusOk;
    result_d = '0;
    if (func_i == spsq_pkg::FuncInsert) begin
      if (is_full) begin
        status_d = spsq_pkg::StatusFull;
      end else begin
        count_d = count_q + CountW'(1);
      end
    end else begin
      if (is_empty) begin
        status_d = spsq_pkg::StatusEmpty;
      end else begin
        count_d  = count_q - CountW'(1);
        result_d = cell_entry[0];
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      result_q <= result_d;
    end
  end

  // fill level modulo 32
  logic [CountW+4:0] count_ext;
  assign count_ext = {5'd0, count_q};

  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign out_process_id_o   = result_q.process_id;
  assign out_burst_length_o = result_q.burst_length;
  assign out_rank_o         = result_q.rank;
  assign fill_level_o       = count_ext[4:0];

  // count never passes the depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(QueueDepth))
    else $error("entry count above queue depth");

  // head and second cell stay in rank order
  a_head_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= CountW'(2)) |-> (cell_entry[0].rank <= cell_entry[1].rank))
    else $error("head entry out of rank order");

  // remove on an empty queue reports empty with zero rank
  a_empty_remove: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && func_i == spsq_pkg::FuncRemove && is_empty) |=>
      (status_q == spsq_pkg::StatusEmpty && result_q.rank == 4'd0 && count_q == '0))
    else $error("empty remove not reported");

  // a successful remove returns the old head
  a_remove_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_remove |=> (result_q == $past(cell_entry[0]) && status_q == spsq_pkg::StatusOk))
    else $error("remove did not return the head entry");

endmodule
